/* rtl/rgbs_pkg.sv */
package rgbs_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned LED_COUNT_DEFAULT   = 16;
  localparam int unsigned LEAD_SLOTS_DEFAULT  = 50;
  localparam int unsigned TRAIL_SLOTS_DEFAULT = 50;

  // Frame layout
  localparam int unsigned BITS_PER_LED = 24;
  localparam int unsigned FULL_SCALE   = 255;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned LED_W   = 8;
  localparam int unsigned COMP_W  = 8;
  localparam int unsigned COLOR_W = 3 * COMP_W;
  localparam int unsigned DUTY_W  = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_RAW_WRITE    = 2'd0;
  localparam logic [OP_W-1:0] OP_SCALED_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_SLOT_TICK    = 2'd2;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_DUTY  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ONE_DUTY   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESET_DUTY = 4'd3;

  // Register reset values
  localparam logic [COMP_W-1:0] BRIGHTNESS_RST = 8'd1;
  localparam logic [DUTY_W-1:0] ZERO_DUTY_RST  = 16'd29;
  localparam logic [DUTY_W-1:0] ONE_DUTY_RST   = 16'd58;
  localparam logic [DUTY_W-1:0] RESET_DUTY_RST = 16'd0;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // One classified item: a colour write or a slot tick
  typedef struct packed {
    logic               is_tick;
    logic [LED_W-1:0]   led;
    logic [COLOR_W-1:0] color;   // green:red:blue
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [DUTY_W-1:0] zero_duty;
    logic [DUTY_W-1:0] one_duty;
    logic [DUTY_W-1:0] reset_duty;
  } duty_cfg_t;

endpackage

/* rtl/rgbs_front.sv */
module rgbs_front #(
  parameter int unsigned LED_COUNT = rgbs_pkg::LED_COUNT_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rgbs_pkg::COMP_W-1:0]  brightness,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rgbs_pkg::OP_W-1:0]    op,
  input  logic [rgbs_pkg::LED_W-1:0]   led_index,
  input  logic [rgbs_pkg::COMP_W-1:0]  red,
  input  logic [rgbs_pkg::COMP_W-1:0]  green,
  input  logic [rgbs_pkg::COMP_W-1:0]  blue,
  output logic                         q_push,
  output rgbs_pkg::q_entry_t           q_wdata,
  input  rgbs_pkg::q_status_t          q_stat
);
  import rgbs_pkg::*;

  localparam int unsigned PROD_W = 2 * COMP_W;

  // floor(x / 255) for any product of two 8-bit values
  function automatic logic [COMP_W-1:0] div_full_scale(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] sum;
    sum = {1'b0, x} + (PROD_W+1)'(1) + (PROD_W+1)'(x[PROD_W-1:COMP_W]);
    return sum[PROD_W-1:COMP_W];
  endfunction

  logic [LED_W-1:0]  mod_table [256];
  logic              accept;
  logic              s1_valid;
  logic              s1_tick;
  logic              s1_scaled;
  logic [LED_W-1:0]  s1_led;
  logic [PROD_W-1:0] s1_red;
  logic [PROD_W-1:0] s1_green;
  logic [PROD_W-1:0] s1_blue;

  // Constant table: LED index modulo the chain length
  always_comb begin
    for (int i = 0; i < 256; i++) begin
      mod_table[i] = LED_W'(i % LED_COUNT);
    end
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = !s1_valid || !q_stat.full;
  assign q_push   = s1_valid && !q_stat.full;

  // Hold the classified item until the queue takes it; drop unused ops
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= (op == OP_RAW_WRITE) || (op == OP_SCALED_WRITE) || (op == OP_SLOT_TICK);
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

  // Register the item, scaled writes multiplied by brightness
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tick   <= (op == OP_SLOT_TICK);
      s1_scaled <= (op == OP_SCALED_WRITE);
      s1_led    <= mod_table[led_index];
      if (op == OP_SCALED_WRITE) begin
        s1_red   <= PROD_W'(brightness) * PROD_W'(red);
        s1_green <= PROD_W'(brightness) * PROD_W'(green);
        s1_blue  <= PROD_W'(brightness) * PROD_W'(blue);
      end else begin
        s1_red   <= {{COMP_W{1'b0}}, red};
        s1_green <= {{COMP_W{1'b0}}, green};
        s1_blue  <= {{COMP_W{1'b0}}, blue};
      end
    end
  end

  // Finish the scaling on the way into the queue
  always_comb begin
    q_wdata.is_tick = s1_tick;
    q_wdata.led     = s1_led;
    if (s1_scaled) begin
      q_wdata.color = {div_full_scale(s1_green), div_full_scale(s1_red),
                       div_full_scale(s1_blue)};
    end else begin
      q_wdata.color = {s1_green[COMP_W-1:0], s1_red[COMP_W-1:0], s1_blue[COMP_W-1:0]};
    end
  end

endmodule

/* rtl/rgbs_queue.sv */
module rgbs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rgbs_pkg::q_entry_t  wdata,
  input  logic                pop,
  output rgbs_pkg::q_entry_t  rdata,
  output rgbs_pkg::q_status_t stat
);
  import rgbs_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  q_entry_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

/* rtl/rgbs_back.sv */
module rgbs_back #(
  parameter int unsigned LED_COUNT   = rgbs_pkg::LED_COUNT_DEFAULT,
  parameter int unsigned LEAD_SLOTS  = rgbs_pkg::LEAD_SLOTS_DEFAULT,
  parameter int unsigned TRAIL_SLOTS = rgbs_pkg::TRAIL_SLOTS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rgbs_pkg::duty_cfg_t          duty_cfg,
  input  rgbs_pkg::q_entry_t           q_rdata,
  input  rgbs_pkg::q_status_t          q_stat,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rgbs_pkg::DUTY_W-1:0]  duty,
  output logic                         frame_end
);
  import rgbs_pkg::*;

  localparam int unsigned DATA_SLOTS  = LED_COUNT * BITS_PER_LED;
  localparam int unsigned FRAME_SLOTS = LEAD_SLOTS + DATA_SLOTS + 1 + TRAIL_SLOTS;
  localparam int unsigned PW          = $clog2(FRAME_SLOTS);
  localparam int unsigned LW          = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned BW          = $clog2(BITS_PER_LED);

  localparam logic [PW-1:0] LEAD_END  = PW'(LEAD_SLOTS);
  localparam logic [PW-1:0] DATA_END  = PW'(LEAD_SLOTS + DATA_SLOTS);
  localparam logic [PW-1:0] LAST_SLOT = PW'(FRAME_SLOTS - 1);
  localparam logic [BW-1:0] LAST_BIT  = BW'(BITS_PER_LED - 1);
  localparam logic [LW-1:0] LAST_LED  = LW'(LED_COUNT - 1);

  // Slot classes
  localparam logic [1:0] SLOT_RESET = 2'd0;
  localparam logic [1:0] SLOT_DATA  = 2'd1;
  localparam logic [1:0] SLOT_STOP  = 2'd2;
  localparam logic [1:0] SLOT_TRAIL = 2'd3;

  logic [COLOR_W-1:0] mem [LED_COUNT];
  logic [LED_COUNT-1:0] mem_valid;
  logic [LW-1:0]      wr_addr;
  logic [PW-1:0]      pos;
  logic [BW-1:0]      bit_ctr;
  logic [LW-1:0]      led_ctr;
  logic [1:0]         slot_class;
  logic               last_slot;
  logic               b_free;
  logic               pop_tick;
  logic               pop_write;
  logic [1:0]         b_class;
  logic [BW-1:0]      b_bit;
  logic [COLOR_W-1:0] rd_data;
  logic               rd_valid;
  logic               data_bit;

  assign wr_addr   = q_rdata.led[LW-1:0];
  assign b_free    = !out_valid || out_ready;
  assign pop_write = !q_stat.empty && !q_rdata.is_tick;
  assign pop_tick  = !q_stat.empty && q_rdata.is_tick && b_free;
  assign q_pop     = pop_write || pop_tick;
  assign last_slot = (pos == LAST_SLOT);

  // Classify the current slot of the frame
  always_comb begin
    if (pos < LEAD_END) begin
      slot_class = SLOT_RESET;
    end else if (pos < DATA_END) begin
      slot_class = SLOT_DATA;
    end else if (pos == DATA_END) begin
      slot_class = SLOT_STOP;
    end else begin
      slot_class = SLOT_TRAIL;
    end
  end

  // Advance the slot counters on each tick, track written LEDs
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
      bit_ctr   <= '0;
      led_ctr   <= '0;
      mem_valid <= '0;
    end else begin
      if (pop_tick) begin
        out_valid <= 1'b1;
        if (last_slot) begin
          pos     <= '0;
          bit_ctr <= '0;
          led_ctr <= '0;
        end else begin
          pos <= pos + 1'b1;
          if (slot_class == SLOT_DATA) begin
            if (bit_ctr == LAST_BIT) begin
              bit_ctr <= '0;
              led_ctr <= (led_ctr == LAST_LED) ? '0 : led_ctr + 1'b1;
            end else begin
              bit_ctr <= bit_ctr + 1'b1;
            end
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop_write) begin
        mem_valid[wr_addr] <= 1'b1;
      end
    end
  end

  // Write colours into the store
  always_ff @(posedge clk) begin
    if (pop_write) begin
      mem[wr_addr] <= q_rdata.color;
    end
  end

  // Load the output stage and the registered colour read
  always_ff @(posedge clk) begin
    if (pop_tick) begin
      b_class   <= slot_class;
      b_bit     <= bit_ctr;
      frame_end <= last_slot;
      rd_data   <= mem[led_ctr];
      rd_valid  <= mem_valid[led_ctr];
    end
  end

  // Pick the bit, MSB first; unwritten LEDs read as black
  assign data_bit = rd_valid && rd_data[LAST_BIT - b_bit];

  // Select the compare value
  always_comb begin
    unique case (b_class)
      SLOT_RESET: duty = duty_cfg.reset_duty;
      SLOT_DATA:  duty = data_bit ? duty_cfg.one_duty : duty_cfg.zero_duty;
      SLOT_STOP:  duty = duty_cfg.zero_duty;
      SLOT_TRAIL: duty = '0;
      default:    duty = '0;
    endcase
  end

endmodule

/* rtl/rgb_led_chain_slot_encoder_core.sv */
// Serial slot encoder for a chain of addressable RGB LEDs. Items enter on the
// in_valid/in_ready channel: op 0 writes a raw colour to led_index modulo
// LED_COUNT, op 1 writes it scaled by the brightness register, op 2 is a slot
// tick that returns one PWM compare value on duty, with frame_end high on the
// last slot of a frame; op 3 is ignored. A frame is LEAD_SLOTS slots of
// reset_duty, 24 bits per LED (green, red, blue, MSB first) as one_duty or
// zero_duty, one zero_duty slot, then TRAIL_SLOTS slots of 0. The block takes
// one item per cycle unless the queue is full. A tick result passes the front
// register that does the brightness multiply and the four-entry queue, and is
// loaded into the output register together with the registered colour-store
// read. The queue absorbs a stalled output, so input stays ready until it
// fills. The colour store reads as black after reset with no clearing pass.
// Registers are written through cfg_wen/cfg_index/cfg_data; the user must do
// so only while no item is in flight, as the block itself does not enforce it.
module rgb_led_chain_slot_encoder_core #(
  parameter int unsigned LED_COUNT   = rgbs_pkg::LED_COUNT_DEFAULT,
  parameter int unsigned LEAD_SLOTS  = rgbs_pkg::LEAD_SLOTS_DEFAULT,
  parameter int unsigned TRAIL_SLOTS = rgbs_pkg::TRAIL_SLOTS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [rgbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rgbs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rgbs_pkg::OP_W-1:0]        op,
  input  logic [rgbs_pkg::LED_W-1:0]       led_index,
  input  logic [rgbs_pkg::COMP_W-1:0]      red,
  input  logic [rgbs_pkg::COMP_W-1:0]      green,
  input  logic [rgbs_pkg::COMP_W-1:0]      blue,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rgbs_pkg::DUTY_W-1:0]      duty,
  output logic                             frame_end
);
  import rgbs_pkg::*;

  logic [COMP_W-1:0] brightness;
  duty_cfg_t         duty_cfg;
  logic              q_push;
  logic              q_pop;
  q_entry_t          q_wdata;
  q_entry_t          q_rdata;
  q_status_t         q_stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness          <= BRIGHTNESS_RST;
      duty_cfg.zero_duty  <= ZERO_DUTY_RST;
      duty_cfg.one_duty   <= ONE_DUTY_RST;
      duty_cfg.reset_duty <= RESET_DUTY_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_BRIGHTNESS: brightness          <= cfg_data[COMP_W-1:0];
        CFG_ZERO_DUTY:  duty_cfg.zero_duty  <= cfg_data[DUTY_W-1:0];
        CFG_ONE_DUTY:   duty_cfg.one_duty   <= cfg_data[DUTY_W-1:0];
        CFG_RESET_DUTY: duty_cfg.reset_duty <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  rgbs_front #(
    .LED_COUNT (LED_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .brightness (brightness),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .led_index  (led_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .q_push     (q_push),
    .q_wdata    (q_wdata),
    .q_stat     (q_stat)
  );

  rgbs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  rgbs_back #(
    .LED_COUNT   (LED_COUNT),
    .LEAD_SLOTS  (LEAD_SLOTS),
    .TRAIL_SLOTS (TRAIL_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .duty_cfg  (duty_cfg),
    .q_rdata   (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .duty      (duty),
    .frame_end (frame_end)
  );

`ifndef NO_ASSERTIONS
  // No result right out of reset
  a_no_out_after_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // The last slot of a frame is a trailing zero slot when there are any
  a_frame_end_trail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> ((TRAIL_SLOTS == 0) || (duty == '0)))
    else $error("frame end on a non-trailing slot");

  // Queue is never reported full and empty at once
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    $onehot0({q_stat.full, q_stat.empty}))
    else $error("queue status inconsistent");
`endif

endmodule
